>>> hw/rtl/merge_sort_engine_macros.svh
// Assertion macros shared by the merge sort engine checkers.
// Every macro samples on clk and is held off while rst_n is low.
`ifndef MERGE_SORT_ENGINE_MACROS_SVH
`define MERGE_SORT_ENGINE_MACROS_SVH

// Plain concurrent assertion on clk, disabled during reset.
`define MSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Antecedent in a given cycle, consequent required in the next cycle.
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  `MSE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/mse_pkg.sv
// Shared constants and types for the merge sort engine.
// No dependencies; used by mse_merge, mse_ram and merge_sort_engine.
package mse_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  // status from the merge unit to the top-level sequencer
  typedef struct packed {
    logic done;      // merge finished this cycle, also when a set needs no pass
    logic res_in_b;  // sorted set ends up in buffer B
    logic src_in_b;  // current pass reads buffer B and writes buffer A
    logic wr_en;     // merged element written this cycle
  } mse_merge_stat_t;

endpackage

>>> hw/rtl/merge_sort_engine.sv
// Merge sort engine top level: load sequencer, ping-pong buffers, output register.
// Depends on mse_pkg, mse_ram and mse_merge.
//
//   channel | ports                         | contents
//   --------+-------------------------------+---------------------------------------
//   in      | in_tvalid/in_tready/in_tdata  | tdata[31:0] value, tlast = last
//   out     | out_tvalid/out_tready/out_tdata| tdata[31:0] value_res, tlast = last_res,
//           |                               | tuser[0] = overflowed
//
// Items load while in_tready is high. After the last item, a bottom-up merge runs
// ceil(log2 n) passes through one shared compare unit (a set of one element
// needs no pass), then a priming state reads the first result and emission runs at one
// result per cycle while the output is not stalled. in_tready is low from the last
// item until the final result is loaded into the output register.
// Reset (rst_n low, synchronous) empties the buffer and drops any output.
// A stalled output holds its result; a new set may load while it waits.
module merge_sort_engine #(
  parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value_res
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // [0] overflowed
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int DW = mse_pkg::DATA_W;

  localparam logic [1:0] S_LOAD   = 2'd0;
  localparam logic [1:0] S_SORT   = 2'd1;
  localparam logic [1:0] S_EPRIME = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          res_b_r, res_b_nxt;
  logic [CW-1:0] e_r, e_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_data_r;
  logic          out_last_r, out_ovf_r;

  logic          in_acc, room, load_we, start, out_load, emit_last;
  logic [DW-1:0] emit_data;

  // buffer ports
  logic          a_we, b_we;
  logic [AW-1:0] a_waddr;
  logic [DW-1:0] a_wdata;
  logic [AW-1:0] rd0_addr, rd1_addr;
  logic [DW-1:0] a_rd0, a_rd1, b_rd0, b_rd1;

  // merge unit
  mse_pkg::mse_merge_stat_t mstat;
  logic [AW-1:0] m_rd_a, m_rd_b, m_waddr;
  logic [DW-1:0] m_wdata, m_src_a, m_src_b;

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign room      = (count_r < CW'(MAX_ITEMS));
  assign load_we   = in_acc && room;
  assign start     = in_acc && in_tlast;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign emit_last = ((e_r + CW'(1)) == count_r);
  assign emit_data = res_b_r ? b_rd0 : a_rd0;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    res_b_nxt     = res_b_r;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          // store while there is room, otherwise drop and flag the set
          if (room) begin
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = S_SORT;
          end
        end
      end
      S_SORT: begin
        if (mstat.done) begin
          res_b_nxt = mstat.res_in_b;
          e_nxt     = '0;
          state_nxt = S_EPRIME;
        end
      end
      S_EPRIME: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          e_nxt         = e_r + CW'(1);
          if (emit_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_b_r <= res_b_nxt;
    e_r     <= e_nxt;
    if (out_load) begin
      out_data_r <= emit_data;
      out_last_r <= emit_last;
      out_ovf_r  <= ovf_r;
    end
  end

  // buffer A takes loads and the merge writes of passes that read B
  assign a_we    = load_we || (mstat.wr_en && mstat.src_in_b);
  assign a_waddr = load_we ? count_r[AW-1:0] : m_waddr;
  assign a_wdata = load_we ? in_tdata : m_wdata;
  assign b_we    = mstat.wr_en && !mstat.src_in_b;

  // emission walks read port 0; otherwise the merge unit drives both ports
  assign rd0_addr = ((state_r == S_EPRIME) || (state_r == S_EMIT)) ? e_nxt[AW-1:0] : m_rd_a;
  assign rd1_addr = m_rd_b;

  assign m_src_a = mstat.src_in_b ? b_rd0 : a_rd0;
  assign m_src_b = mstat.src_in_b ? b_rd1 : a_rd1;

  mse_ram #(.DEPTH(MAX_ITEMS)) u_buf_a (
    .clk    (clk),
    .we     (a_we),
    .waddr  (a_waddr),
    .wdata  (a_wdata),
    .raddr0 (rd0_addr),
    .raddr1 (rd1_addr),
    .rdata0 (a_rd0),
    .rdata1 (a_rd1)
  );

  mse_ram #(.DEPTH(MAX_ITEMS)) u_buf_b (
    .clk    (clk),
    .we     (b_we),
    .waddr  (m_waddr),
    .wdata  (m_wdata),
    .raddr0 (rd0_addr),
    .raddr1 (rd1_addr),
    .rdata0 (b_rd0),
    .rdata1 (b_rd1)
  );

  mse_merge #(.MAX_ITEMS(MAX_ITEMS)) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (start),
    .n_i         (count_nxt),
    .rd_a_i      (m_src_a),
    .rd_b_i      (m_src_b),
    .rd_addr_a_o (m_rd_a),
    .rd_addr_b_o (m_rd_b),
    .wr_addr_o   (m_waddr),
    .wr_data_o   (m_wdata),
    .stat_o      (mstat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

>>> hw/rtl/mse_ram.sv
// Simple dual-read, single-write RAM with registered read data.
// Depends on mse_pkg for the data width.
module mse_ram #(
  parameter int DEPTH = mse_pkg::MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [mse_pkg::DATA_W-1:0]   wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr0,
  input  logic [$clog2(DEPTH)-1:0]     raddr1,
  output logic [mse_pkg::DATA_W-1:0]   rdata0,
  output logic [mse_pkg::DATA_W-1:0]   rdata1
);

  logic [mse_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> hw/rtl/mse_merge.sv
// Bottom-up merge unit: one shared signed compare drives all passes.
// Depends on mse_pkg; reads and writes the two buffers through the top level.
module mse_merge #(
  parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]     n_i,
  input  logic [mse_pkg::DATA_W-1:0]         rd_a_i,
  input  logic [mse_pkg::DATA_W-1:0]         rd_b_i,
  output logic [$clog2(MAX_ITEMS)-1:0]       rd_addr_a_o,
  output logic [$clog2(MAX_ITEMS)-1:0]       rd_addr_b_o,
  output logic [$clog2(MAX_ITEMS)-1:0]       wr_addr_o,
  output logic [mse_pkg::DATA_W-1:0]         wr_data_o,
  output mse_pkg::mse_merge_stat_t           stat_o
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = CW + 2;
  localparam int SW = PW + 1;

  localparam logic [1:0] M_IDLE  = 2'd0;
  localparam logic [1:0] M_PRIME = 2'd1;
  localparam logic [1:0] M_RUN   = 2'd2;

  logic [1:0]    st_r, st_nxt;
  logic [PW-1:0] n_r, n_nxt;
  logic [PW-1:0] w_r, w_nxt;
  logic [PW-1:0] i_r, i_nxt;
  logic [PW-1:0] j_r, j_nxt;
  logic [PW-1:0] mid_r, mid_nxt;
  logic [PW-1:0] hi_r, hi_nxt;
  logic [PW-1:0] k_r, k_nxt;
  logic          src_b_r, src_b_nxt;

  logic          take_l;
  logic [PW-1:0] k1, w2, n_ext;
  logic          run_end, pass_end, all_done;
  logic [SW-1:0] s_mid, s_hi, p_hi2;
  logic [PW-1:0] r_mid, r_hi, p_mid, p_hi;
  logic          done, res_b;

  assign n_ext = PW'(n_i);
  assign take_l = (i_r < mid_r) &&
                  ((j_r >= hi_r) || ($signed(rd_a_i) <= $signed(rd_b_i)));
  assign k1       = k_r + PW'(1);
  assign w2       = {w_r[PW-2:0], 1'b0};
  assign run_end  = (k1 == hi_r);
  assign pass_end = run_end && (hi_r == n_r);
  assign all_done = pass_end && (w2 >= n_r);

  // bounds of the next run pair within this pass
  assign s_mid = {1'b0, hi_r} + {1'b0, w_r};
  assign s_hi  = {1'b0, hi_r} + {1'b0, w2};
  assign r_mid = (s_mid > {1'b0, n_r}) ? n_r : s_mid[PW-1:0];
  assign r_hi  = (s_hi  > {1'b0, n_r}) ? n_r : s_hi[PW-1:0];
  // bounds of the first run pair of the next pass
  assign p_hi2 = {w2, 1'b0};
  assign p_mid = (w2 > n_r) ? n_r : w2;
  assign p_hi  = (p_hi2 > {1'b0, n_r}) ? n_r : p_hi2[PW-1:0];

  always_comb begin
    st_nxt    = st_r;
    n_nxt     = n_r;
    w_nxt     = w_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    k_nxt     = k_r;
    src_b_nxt = src_b_r;
    done      = 1'b0;
    res_b     = src_b_r;
    unique case (st_r)
      M_IDLE: begin
        if (start_i) begin
          n_nxt     = n_ext;
          w_nxt     = PW'(1);
          src_b_nxt = 1'b0;
          i_nxt     = '0;
          mid_nxt   = PW'(1);
          j_nxt     = PW'(1);
          hi_nxt    = (n_ext >= PW'(2)) ? PW'(2) : n_ext;
          k_nxt     = '0;
          st_nxt    = M_PRIME;
        end
      end
      M_PRIME: begin
        // read data for the pass head lands this cycle
        if (w_r >= n_r) begin
          done   = 1'b1;
          st_nxt = M_IDLE;
        end else begin
          st_nxt = M_RUN;
        end
      end
      M_RUN: begin
        if (all_done) begin
          done   = 1'b1;
          res_b  = ~src_b_r;
          st_nxt = M_IDLE;
        end else if (pass_end) begin
          w_nxt     = w2;
          src_b_nxt = ~src_b_r;
          i_nxt     = '0;
          mid_nxt   = p_mid;
          j_nxt     = p_mid;
          hi_nxt    = p_hi;
          k_nxt     = '0;
          st_nxt    = M_PRIME;
        end else if (run_end) begin
          i_nxt   = hi_r;
          mid_nxt = r_mid;
          j_nxt   = r_mid;
          hi_nxt  = r_hi;
          k_nxt   = k1;
        end else begin
          i_nxt = take_l ? i_r + PW'(1) : i_r;
          j_nxt = take_l ? j_r : j_r + PW'(1);
          k_nxt = k1;
        end
      end
      default: st_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= M_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    w_r     <= w_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    mid_r   <= mid_nxt;
    hi_r    <= hi_nxt;
    k_r     <= k_nxt;
    src_b_r <= src_b_nxt;
  end

  // read ports follow the next head pointers so the read data is the current head
  assign rd_addr_a_o = i_nxt[AW-1:0];
  assign rd_addr_b_o = j_nxt[AW-1:0];
  assign wr_addr_o   = k_r[AW-1:0];
  assign wr_data_o   = take_l ? rd_a_i : rd_b_i;

  assign stat_o.done     = done;
  assign stat_o.res_in_b = res_b;
  assign stat_o.src_in_b = src_b_r;
  assign stat_o.wr_en    = (st_r == M_RUN);

endmodule

>>> hw/rtl/mse_chk.sv
// Port-level checker for the merge sort engine, bound to the top level.
// Depends on merge_sort_engine_macros.svh.
`include "merge_sort_engine_macros.svh"

module mse_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  logic        in_acc;
  logic        out_stall;
  logic [33:0] out_word;

  assign in_acc    = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_word  = {out_tuser, out_tlast, out_tdata};

  // a stalled result holds its value and markers
  `MSE_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_word), "held result changed")

  // the last item of a set closes the input
  `MSE_ASSERT_NEXT(a_last_blocks, in_acc && in_tlast, !in_tready, "input open after last item")

  // loading continues until the last item of the set
  `MSE_ASSERT_NEXT(a_load_open, in_acc && !in_tlast, in_tready, "input closed mid set")

endmodule

bind merge_sort_engine mse_chk u_mse_chk (.*);
